### design/llsd_pkg.sv
package llsd_pkg;

	// Field widths fixed by the interface.
	localparam int SRV_W     = 3;
	localparam int JOB_W     = 16;
	localparam int LOAD_W    = 7;
	localparam int RID_W     = 6;

	// Job count registers on the configuration port.
	localparam int NUM_CFG   = 5;
	localparam int CFG_IDX_W = 3;

	// Load counters saturate at their all-ones value.
	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	// Operations applied to the server state bank.
	typedef enum logic [1:0] {
		SRV_OP_NONE,
		SRV_OP_DEC,
		SRV_OP_GRANT
	} srv_op_t;

	// Command from the sequencer: operation plus the server it addresses.
	typedef struct packed {
		srv_op_t            op;
		logic [SRV_W-1:0]   idx;
	} srv_cmd_t;

	// State of the addressed server as seen by the sequencer.
	typedef struct packed {
		logic               open;
		logic [LOAD_W-1:0]  load;
		logic [JOB_W-1:0]   next_job;
	} srv_rd_t;

	// Configuration register write.
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] idx;
		logic [JOB_W-1:0]     data;
	} cfg_wr_t;

endpackage

### design/llsd_req_table.sv
module llsd_req_table #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic                       rd_valid,
	output logic [llsd_pkg::SRV_W-1:0] rd_server,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic                       wr_valid,
	input  logic [llsd_pkg::SRV_W-1:0] wr_server
);
	import llsd_pkg::*;

	logic [SRV_W-1:0] mem_q [DEPTH];
	logic             valid_q [DEPTH];

	// Server codes live in a plain memory with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_server;
		end
		if (rd_en) begin
			rd_server <= mem_q[rd_addr];
		end
	end

	// One valid bit per requester; reset marks every entry as having no server.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end
			if (rd_en) begin
				rd_valid <= valid_q[rd_addr];
			end
		end
	end

endmodule

### design/llsd_server_bank.sv
module llsd_server_bank #(
	parameter int NUM_SERVERS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  llsd_pkg::cfg_wr_t              cfg_wr,
	input  logic [llsd_pkg::CFG_IDX_W-1:0] cfg_rd_idx,
	output logic [llsd_pkg::JOB_W-1:0]     cfg_rd_data,
	input  llsd_pkg::srv_cmd_t             cmd,
	output llsd_pkg::srv_rd_t              rd
);
	import llsd_pkg::*;

	localparam int SIW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

	logic [JOB_W-1:0]  jobs_q [NUM_CFG];
	logic [LOAD_W-1:0] load_q [NUM_SERVERS];
	logic [JOB_W-1:0]  next_q [NUM_SERVERS];
	logic              fin_q  [NUM_SERVERS];

	logic [SIW-1:0]    addr;
	logic [JOB_W-1:0]  count;
	logic [JOB_W:0]    next_inc;

	assign addr = cmd.idx[SIW-1:0];

	// Servers without a job register have no jobs.
	always_comb begin
		if (cmd.idx < SRV_W'(NUM_CFG)) begin
			count = jobs_q[cmd.idx];
		end else begin
			count = '0;
		end
	end

	assign next_inc = {1'b0, next_q[addr]} + {{JOB_W{1'b0}}, 1'b1};

	// A server is open while not flagged finished and jobs remain.
	assign rd.open     = !fin_q[addr] && (next_q[addr] < count);
	assign rd.load     = load_q[addr];
	assign rd.next_job = next_q[addr];

	// Register readback for the configuration port.
	always_comb begin
		if (cfg_rd_idx < CFG_IDX_W'(NUM_CFG)) begin
			cfg_rd_data = jobs_q[cfg_rd_idx];
		end else begin
			cfg_rd_data = '0;
		end
	end

	// Job count registers and per-server state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				jobs_q[i] <= '0;
			end
			for (int i = 0; i < NUM_SERVERS; i++) begin
				load_q[i] <= '0;
				next_q[i] <= '0;
				fin_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_wr.we && (cfg_wr.idx < CFG_IDX_W'(NUM_CFG))) begin
				jobs_q[cfg_wr.idx] <= cfg_wr.data;
			end
			unique case (cmd.op)
				SRV_OP_DEC: begin
					if (load_q[addr] != '0) begin
						load_q[addr] <= load_q[addr] - LOAD_W'(1);
					end
				end
				SRV_OP_GRANT: begin
					next_q[addr] <= next_inc[JOB_W-1:0];
					if (next_inc >= {1'b0, count}) begin
						fin_q[addr] <= 1'b1;
					end
					if (load_q[addr] != LOAD_MAX) begin
						load_q[addr] <= load_q[addr] + LOAD_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### design/least_loaded_server_dispatch.sv
// Least-loaded job dispatcher.
//
// Workers send a requester id on the slave stream (s_tdata[5:0]). For each
// transaction the block first releases one unit of load on the server that
// requester was last given, then scans the servers one per cycle with a
// single load comparator, picks the open server with the smallest load
// (lowest index on ties) and grants its next job index. The result leaves on
// the master stream: m_tuser is the grant flag, m_tdata carries the server
// and job index, both zero when no work is left.
// Job counts per server are set over the APB port at byte addresses 0..16.
// From accept to m_tvalid the steps are: the table read on the accepting edge,
// the load release, the scan through every server, and the write-back.
// s_tready is high only while idle, so a new transaction is taken only after
// the last one has committed its result.
// A finished result sits in the output register; if the receiver stalls, the
// next transaction is still accepted and processed, and holds in its
// write-back step until the output register frees up.
// Reset clears all loads, job positions, finished flags, job counts and the
// requester table.
module least_loaded_server_dispatch #(
	parameter int NUM_REQUESTERS = 64,
	parameter int NUM_SERVERS    = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] requester_id
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] server_index, [18:3] job_index
	output logic        m_tuser    // [0] granted
);
	import llsd_pkg::*;

	localparam int TAB_DEPTH = (NUM_REQUESTERS < (1 << RID_W)) ? NUM_REQUESTERS : (1 << RID_W);
	localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DEC   = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_GRANT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [TAB_AW-1:0]  rid_q;
	logic               in_tab_q;
	logic [SRV_W-1:0]   idx_q;
	logic [SRV_W-1:0]   best_q;
	logic [LOAD_W-1:0]  best_load_q;
	logic               found_q;

	logic               out_valid_q;
	logic               out_granted_q;
	logic [SRV_W-1:0]   out_srv_q;
	logic [JOB_W-1:0]   out_job_q;

	logic               accept;
	logic               commit;
	logic               in_table;
	logic               tab_valid;
	logic [SRV_W-1:0]   tab_server;
	logic               prev_ok;
	logic               better;
	cfg_wr_t            cfg_wr;
	logic [JOB_W-1:0]   cfg_rd_data;
	srv_cmd_t           cmd;
	srv_rd_t            srv_rd;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_table = int'(s_tdata[RID_W-1:0]) < NUM_REQUESTERS;
	assign commit   = (state_q == ST_GRANT) && (!out_valid_q || m_tready);

	// Configuration port: writes complete in the access phase, reads are direct.
	assign pready      = 1'b1;
	assign cfg_wr.we   = psel && penable && pwrite && pready;
	assign cfg_wr.idx  = paddr[4:2];
	assign cfg_wr.data = pwdata[JOB_W-1:0];
	assign prdata      = {{(32 - JOB_W){1'b0}}, cfg_rd_data};

	// Release only for a remembered server that exists.
	assign prev_ok = in_tab_q && tab_valid && (int'(tab_server) < NUM_SERVERS);

	// Shared comparator: is the server under scan a better pick so far?
	assign better = srv_rd.open && (!found_q || (srv_rd.load < best_load_q));

	// Address and operation for the server bank, chosen by the sequencer step.
	always_comb begin
		cmd.op  = SRV_OP_NONE;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_DEC: begin
				cmd.idx = tab_server;
				if (prev_ok) begin
					cmd.op = SRV_OP_DEC;
				end
			end
			ST_SCAN: begin
				cmd.idx = idx_q;
			end
			ST_GRANT: begin
				cmd.idx = best_q;
				if (commit && found_q) begin
					cmd.op = SRV_OP_GRANT;
				end
			end
			default: begin
				cmd.idx = idx_q;
			end
		endcase
	end

	llsd_req_table #(
		.DEPTH(TAB_DEPTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (s_tdata[TAB_AW-1:0]),
		.rd_valid  (tab_valid),
		.rd_server (tab_server),
		.wr_en     (commit && in_tab_q),
		.wr_addr   (rid_q),
		.wr_valid  (found_q),
		.wr_server (found_q ? best_q : '1)
	);

	llsd_server_bank #(
		.NUM_SERVERS(NUM_SERVERS)
	) u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_rd_idx  (paddr[4:2]),
		.cfg_rd_data (cfg_rd_data),
		.cmd         (cmd),
		.rd          (srv_rd)
	);

	// Sequencer: table read, load release, server scan, write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (idx_q == SRV_W'(NUM_SERVERS - 1)) begin
						state_q <= ST_GRANT;
					end else begin
						idx_q <= idx_q + SRV_W'(1);
					end
				end
				ST_GRANT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request context and best-so-far tracking.
	always_ff @(posedge clk) begin
		if (accept) begin
			rid_q    <= s_tdata[TAB_AW-1:0];
			in_tab_q <= in_table;
		end
		if ((state_q == ST_SCAN) && better) begin
			best_q      <= idx_q;
			best_load_q <= srv_rd.load;
		end
	end

	// Output register toward the result stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_granted_q <= found_q;
			out_srv_q     <= found_q ? best_q : '0;
			out_job_q     <= found_q ? srv_rd.next_job : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = {{(24 - SRV_W - JOB_W){1'b0}}, out_job_q, out_srv_q};

endmodule
